>>> hdl/i2cmbe_pkg.sv
package i2cmbe_pkg;

  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [15:0] UNIT_TICKS_RESET = 16'd100;
  localparam logic [1:0] DLY_ONE = 2'd1;
  localparam logic [1:0] DLY_TWO = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_S_SDA1   = 5'd1,
    PH_S_SCL1   = 5'd2,
    PH_S_SDA0   = 5'd3,
    PH_S_SCL0   = 5'd4,
    PH_P_SDA0   = 5'd5,
    PH_P_SCL1   = 5'd6,
    PH_P_SDA1   = 5'd7,
    PH_W_BIT    = 5'd8,
    PH_W_SCL1   = 5'd9,
    PH_W_SCL0   = 5'd10,
    PH_W_REL    = 5'd11,
    PH_R_SCL1   = 5'd12,
    PH_R_SAMPLE = 5'd13,
    PH_A_SDA    = 5'd14,
    PH_A_SCL1   = 5'd15,
    PH_A_SCL0   = 5'd16,
    PH_A_SDA1   = 5'd17,
    PH_K_SDA1   = 5'd18,
    PH_K_SCL1   = 5'd19,
    PH_K_SAMPLE = 5'd20
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_mode;
    logic       sda_in;
  } i2cmbe_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
  } i2cmbe_out_t;

endpackage

>>> hdl/i2c_master_bit_engine.sv
// I2C master bit engine. Every input transfer is one tick of bus timing: it carries the sampled
// SDA level and, while the engine is idle, an optional command (start, stop, write byte, read
// byte with ACK or NACK, wait for ACK). Each tick yields exactly one result transfer with the
// open-drain SCL/SDA drive levels, busy, a one-tick done pulse, the last received byte and the
// last sampled ACK bit. Work for a tick is one pass of logic from the engine state to a result
// register, so a tick is taken every clock cycle; a two-entry output buffer lets one more tick
// in while a result waits, after which in_ready drops until the sink takes a result. Bus delays
// are counted in ticks, unit_ticks per delay unit (zero behaves as one); write unit_ticks only
// while the engine is idle.
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  i2cmbe_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output i2cmbe_out_t out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] unit_ticks;
  phase_t      phase;
  logic [3:0]  bit_count;
  logic [7:0]  shift_reg;
  logic [15:0] delay_count;
  logic [1:0]  delay_units;
  logic        scl_drive;
  logic        sda_drive;
  logic [7:0]  read_result;
  logic        ack_result;
  logic        ack_choice;

  phase_t      phase_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_reg_next;
  logic [15:0] delay_count_next;
  logic [1:0]  delay_units_next;
  logic        scl_drive_next;
  logic        sda_drive_next;
  logic [7:0]  read_result_next;
  logic        ack_result_next;
  logic        ack_choice_next;

  phase_t      op_phase;
  logic        active;
  logic        busy_next;
  logic        accept;
  i2cmbe_out_t result;

  logic        skid_valid;
  i2cmbe_out_t skid_data;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      unit_ticks <= cfg_wr_data;
    end
  end

  // decode and single operation of this tick
  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    delay_units_next = delay_units;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    read_result_next = read_result;
    ack_result_next  = ack_result;
    ack_choice_next  = ack_choice;
    op_phase         = PH_IDLE;
    active           = (phase != PH_IDLE) || (delay_units != 2'd0);

    if (delay_units != 2'd0) begin
      if (delay_count <= 16'd1) begin
        delay_units_next = delay_units - DLY_ONE;
        delay_count_next = unit_ticks;
      end else begin
        delay_count_next = delay_count - 16'd1;
      end
    end else if (phase != PH_IDLE) begin
      op_phase = phase;
    end else begin
      bit_count_next = '0;
      case (in_data.command)
        CMD_START: op_phase = PH_S_SDA1;
        CMD_STOP: op_phase = PH_P_SDA0;
        CMD_WRITE: begin
          op_phase       = PH_W_BIT;
          shift_reg_next = in_data.tx_byte;
        end
        CMD_READ: begin
          op_phase        = PH_R_SCL1;
          shift_reg_next  = '0;
          ack_choice_next = in_data.ack_mode;
        end
        CMD_WAIT_ACK: op_phase = PH_K_SDA1;
        default: op_phase = PH_IDLE;
      endcase
      if (op_phase != PH_IDLE) begin
        active = 1'b1;
      end
    end

    if (op_phase != PH_IDLE) begin
      phase_next       = PH_IDLE;
      delay_units_next = '0;
      delay_count_next = unit_ticks;
      case (op_phase)
        PH_S_SDA1: begin
          sda_drive_next = 1'b1;
          phase_next     = PH_S_SCL1;
        end
        PH_S_SCL1: begin
          scl_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_S_SDA0;
        end
        PH_S_SDA0: begin
          sda_drive_next   = 1'b0;
          delay_units_next = DLY_TWO;
          phase_next       = PH_S_SCL0;
        end
        PH_S_SCL0: scl_drive_next = 1'b0;
        PH_P_SDA0: begin
          sda_drive_next   = 1'b0;
          delay_units_next = DLY_TWO;
          phase_next       = PH_P_SCL1;
        end
        PH_P_SCL1: begin
          scl_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_P_SDA1;
        end
        PH_P_SDA1: sda_drive_next = 1'b1;
        PH_W_BIT: begin
          sda_drive_next   = shift_reg_next[7];
          delay_units_next = DLY_TWO;
          phase_next       = PH_W_SCL1;
        end
        PH_W_SCL1: begin
          scl_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_W_SCL0;
        end
        PH_W_SCL0: begin
          scl_drive_next = 1'b0;
          shift_reg_next = {shift_reg_next[6:0], 1'b0};
          bit_count_next = bit_count_next + 4'd1;
          phase_next     = (bit_count_next >= BYTE_BITS) ? PH_W_REL : PH_W_BIT;
        end
        PH_W_REL: sda_drive_next = 1'b1;
        PH_R_SCL1: begin
          scl_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_R_SAMPLE;
        end
        PH_R_SAMPLE: begin
          shift_reg_next   = {shift_reg_next[6:0], in_data.sda_in};
          scl_drive_next   = 1'b0;
          delay_units_next = DLY_ONE;
          bit_count_next   = bit_count_next + 4'd1;
          if (bit_count_next >= BYTE_BITS) begin
            read_result_next = shift_reg_next;
            phase_next       = PH_A_SDA;
          end else begin
            phase_next = PH_R_SCL1;
          end
        end
        PH_A_SDA: begin
          sda_drive_next = ack_choice_next;
          phase_next     = PH_A_SCL1;
        end
        PH_A_SCL1: begin
          scl_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_A_SCL0;
        end
        PH_A_SCL0: begin
          scl_drive_next = 1'b0;
          if (ack_choice_next) begin
            delay_units_next = DLY_TWO;
          end else begin
            phase_next = PH_A_SDA1;
          end
        end
        PH_A_SDA1: begin
          sda_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
        end
        PH_K_SDA1: begin
          sda_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_K_SCL1;
        end
        PH_K_SCL1: begin
          scl_drive_next   = 1'b1;
          delay_units_next = DLY_TWO;
          phase_next       = PH_K_SAMPLE;
        end
        PH_K_SAMPLE: begin
          ack_result_next  = in_data.sda_in;
          scl_drive_next   = 1'b0;
          delay_units_next = DLY_TWO;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    busy_next          = (phase_next != PH_IDLE) || (delay_units_next != 2'd0);
    result.scl_level   = scl_drive_next;
    result.sda_level   = sda_drive_next;
    result.busy_res    = busy_next;
    result.done_res    = active && !busy_next;
    result.rx_byte     = read_result_next;
    result.nack_seen   = ack_result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      delay_units <= '0;
      scl_drive   <= 1'b1;
      sda_drive   <= 1'b1;
      read_result <= '0;
      ack_result  <= 1'b0;
      ack_choice  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      delay_units <= delay_units_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
      read_result <= read_result_next;
      ack_result  <= ack_result_next;
      ack_choice  <= ack_choice_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BYTE_BITS)
    else $error("bit counter beyond one byte");

  a_delay_unit_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && (delay_units != 2'd0) && (delay_count > 16'd1))
      |=> (delay_units == $past(delay_units)) && (phase == $past(phase)))
    else $error("delay unit ended early");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done reported while busy");

  a_skid_data_held: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !out_ready) |=> skid_valid && $stable(skid_data))
    else $error("skid entry lost while output stalled");
`endif

endmodule
